### rtl/cae_pkg.sv
// Shared types, codes and constants of the client admission table.
package cae_pkg;

  // Default number of client entries.
  localparam int unsigned DefTableDepth = 8;

  // Depth of the command queue between the front and back parts.
  localparam int unsigned CmdDepth = 2;

  // Configuration port address width: six registers at 4-byte spacing.
  localparam int unsigned PaddrW = 5;

  typedef enum logic [1:0] {
    ReqAdmit   = 2'd0,
    ReqRelease = 2'd1,
    ReqUpdate  = 2'd2,
    ReqShed    = 2'd3
  } cae_req_e;

  typedef enum logic [1:0] {
    PolicyReject   = 2'd0,
    PolicySlowest  = 2'd1,
    PolicyTakeover = 2'd2
  } cae_policy_e;

  typedef enum logic [3:0] {
    StatAccepted = 4'd0,
    StatReplSlow = 4'd1,
    StatReplTake = 4'd2,
    StatRejMem   = 4'd3,
    StatRejCap   = 4'd4,
    StatReleased = 4'd5,
    StatNotFound = 4'd6,
    StatUpdated  = 4'd7,
    StatShed     = 4'd8,
    StatNoShed   = 4'd9
  } cae_status_e;

  typedef enum logic [2:0] {
    RegMaxClients = 3'd0,
    RegPolicy     = 3'd1,
    RegRejHeap    = 3'd2,
    RegRejBlock   = 3'd3,
    RegShedHeap   = 3'd4,
    RegShedBlock  = 3'd5
  } cae_reg_e;

  typedef enum logic [1:0] {
    StIdle = 2'd0,
    StScan = 2'd1,
    StExec = 2'd2
  } cae_state_e;

  typedef struct packed {
    logic [7:0]  max_clients;
    logic [1:0]  policy;
    logic [31:0] rej_heap;
    logic [31:0] rej_block;
    logic [31:0] shed_heap;
    logic [31:0] shed_block;
  } cae_cfg_t;

  // Classified request as it travels from front to back.
  typedef struct packed {
    cae_req_e    req;
    logic [31:0] client_id;
    logic        takeover;
    logic        queue_full;
    logic [15:0] queue_len;
    logic [31:0] now_ms;
    logic        mem_ok;
    logic        critical;
  } cae_cmd_t;

  typedef struct packed {
    cae_status_e status;
    logic        evicted_valid;
    logic [31:0] evicted_id;
    logic [7:0]  active_count;
    logic [31:0] rejected_total;
    logic [31:0] evicted_total;
  } cae_res_t;

endpackage

### rtl/cae_front.sv
// Front part: accepts request words, classifies memory pressure, queues commands.
module cae_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cae_pkg::cae_cfg_t  cfg_i,
  input  logic               push_i,
  output logic               full_o,
  input  logic [1:0]         req_type_i,
  input  logic [31:0]        client_id_i,
  input  logic               takeover_i,
  input  logic               queue_full_i,
  input  logic [15:0]        queue_len_i,
  input  logic [31:0]        free_heap_i,
  input  logic [31:0]        largest_block_i,
  input  logic [31:0]        now_ms_i,
  output logic               cmd_valid_o,
  output cae_pkg::cae_cmd_t  cmd_o,
  input  logic               cmd_pop_i
);
  import cae_pkg::*;

  localparam int unsigned PtrW = (CmdDepth > 1) ? $clog2(CmdDepth) : 1;

  cae_cmd_t          cmd_new;
  cae_cmd_t          queue_q [CmdDepth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [PtrW:0]     cnt_q, cnt_d;
  logic              headroom;
  logic              critical;
  logic              push_ok;
  logic              pop_ok;

  // Classify against the thresholds as the word arrives.
  assign headroom = (free_heap_i >= cfg_i.rej_heap) && (largest_block_i >= cfg_i.rej_block);
  assign critical = !((free_heap_i >= cfg_i.shed_heap) && (largest_block_i >= cfg_i.shed_block));

  always_comb begin
    cmd_new            = '0;
    cmd_new.req        = cae_req_e'(req_type_i);
    cmd_new.client_id  = client_id_i;
    cmd_new.takeover   = takeover_i;
    cmd_new.queue_full = queue_full_i;
    cmd_new.queue_len  = queue_len_i;
    cmd_new.now_ms     = now_ms_i;
    cmd_new.mem_ok     = headroom && !critical;
    cmd_new.critical   = critical;
  end

  assign full_o      = (cnt_q == (PtrW+1)'(CmdDepth));
  assign cmd_valid_o = (cnt_q != '0);
  assign cmd_o       = queue_q[rd_ptr_q];
  assign push_ok     = push_i && !full_o;
  assign pop_ok      = cmd_pop_i && cmd_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_ok) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(CmdDepth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_ok) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(CmdDepth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_ok && !pop_ok) begin
      cnt_d = cnt_q + (PtrW+1)'(1);
    end else if (pop_ok && !push_ok) begin
      cnt_d = cnt_q - (PtrW+1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      queue_q[wr_ptr_q] <= cmd_new;
    end
  end

endmodule

### rtl/cae_back.sv
// Back part: scans the client table, carries out a command, holds the result.
module cae_back #(
  parameter int unsigned TableDepth = cae_pkg::DefTableDepth
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cae_pkg::cae_cfg_t  cfg_i,
  input  logic               cmd_valid_i,
  input  cae_pkg::cae_cmd_t  cmd_i,
  output logic               cmd_pop_o,
  output logic               res_valid_o,
  output cae_pkg::cae_res_t  res_o,
  input  logic               res_pop_i
);
  import cae_pkg::*;

  localparam int unsigned IdxW = (TableDepth > 1) ? $clog2(TableDepth) : 1;

  cae_state_e        state_q, state_d;
  cae_cmd_t          cmd_q;
  logic [IdxW-1:0]   scan_idx_q;
  logic              scan_en, scan_last, exec_go;

  // Table
  logic [TableDepth-1:0] act_q, act_d;
  logic [TableDepth-1:0] full_q;
  logic [31:0]           ids_q   [TableDepth];
  logic [31:0]           times_q [TableDepth];
  logic [15:0]           qlen_q  [TableDepth];

  // Scan trackers
  logic              hit_found_q, free_found_q, slow_found_q, old_found_q;
  logic [IdxW-1:0]   hit_idx_q, free_idx_q, slow_idx_q, old_idx_q;
  logic              slow_full_q;
  logic [15:0]       slow_qlen_q;
  logic [31:0]       slow_id_q, old_id_q, old_time_q;
  logic              hit_take, free_take, slow_take, old_take;

  logic              e_act, e_full;
  logic [15:0]       e_qlen;
  logic [31:0]       e_id, e_time;

  // Execute decisions
  cae_status_e       status;
  logic              evict_en, ins_en, rel_en, upd_en, rej_en;
  logic [IdxW-1:0]   evict_idx, ins_idx;
  logic [31:0]       evict_id;
  logic [7:0]        active_q, active_dec, active_d;
  logic [31:0]       rej_cnt_q, ev_cnt_q;
  cae_res_t          res_q, res_d;
  logic              res_valid_q;

  // ---------------------------------------------------------------- control
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: if (cmd_valid_i) state_d = StScan;
      StScan: if (scan_last) state_d = StExec;
      StExec: if (!res_valid_q) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    cmd_pop_o = (state_q == StIdle) && cmd_valid_i;
    scan_en   = (state_q == StScan);
    exec_go   = (state_q == StExec) && !res_valid_q;
  end

  assign scan_last = (scan_idx_q == IdxW'(TableDepth - 1));

  // ---------------------------------------------------------------- scan
  assign e_act  = act_q[scan_idx_q];
  assign e_full = full_q[scan_idx_q];
  assign e_qlen = qlen_q[scan_idx_q];
  assign e_id   = ids_q[scan_idx_q];
  assign e_time = times_q[scan_idx_q];

  assign hit_take  = scan_en && e_act && !hit_found_q && (e_id == cmd_q.client_id);
  assign free_take = scan_en && !e_act && !free_found_q;
  // Full queue wins, then strictly longer queue; ties keep the lower index.
  assign slow_take = scan_en && e_act &&
                     (!slow_found_q || (e_full && !slow_full_q) ||
                      ((e_full == slow_full_q) && (e_qlen > slow_qlen_q)));
  assign old_take  = scan_en && e_act && (!old_found_q || (e_time < old_time_q));

  // ---------------------------------------------------------------- execute
  always_comb begin
    status    = StatNotFound;
    evict_en  = 1'b0;
    evict_idx = slow_idx_q;
    evict_id  = slow_id_q;
    ins_en    = 1'b0;
    ins_idx   = free_idx_q;
    rel_en    = 1'b0;
    upd_en    = 1'b0;
    rej_en    = 1'b0;
    unique case (cmd_q.req)
      ReqAdmit: begin
        if (!cmd_q.mem_ok) begin
          status = StatRejMem;
          rej_en = 1'b1;
        end else if (active_q >= cfg_i.max_clients) begin
          if ((cfg_i.policy == PolicySlowest) && slow_found_q &&
              (slow_full_q || (slow_qlen_q != '0))) begin
            status   = StatReplSlow;
            evict_en = 1'b1;
          end else if ((cfg_i.policy == PolicyTakeover) && cmd_q.takeover && old_found_q) begin
            status    = StatReplTake;
            evict_en  = 1'b1;
            evict_idx = old_idx_q;
            evict_id  = old_id_q;
          end else begin
            status = StatRejCap;
            rej_en = 1'b1;
          end
          // The evicted entry frees up; take it unless a lower one was free.
          if (evict_en) begin
            ins_en  = 1'b1;
            ins_idx = (free_found_q && (free_idx_q < evict_idx)) ? free_idx_q : evict_idx;
          end
        end else if (free_found_q) begin
          status = StatAccepted;
          ins_en = 1'b1;
        end else begin
          status = StatRejCap;
          rej_en = 1'b1;
        end
      end
      ReqRelease: begin
        if (hit_found_q) begin
          status = StatReleased;
          rel_en = 1'b1;
        end
      end
      ReqUpdate: begin
        if (hit_found_q) begin
          status = StatUpdated;
          upd_en = 1'b1;
        end
      end
      ReqShed: begin
        if (cmd_q.critical && slow_found_q) begin
          status   = StatShed;
          evict_en = 1'b1;
        end else begin
          status = StatNoShed;
        end
      end
      default: status = StatNotFound;
    endcase
  end

  always_comb begin
    active_dec = ((evict_en || rel_en) && (active_q != '0)) ? active_q - 8'd1 : active_q;
    active_d   = ins_en ? active_dec + 8'd1 : active_dec;
  end

  // Clear before set: an evicted entry may be refilled at once.
  always_comb begin
    act_d = act_q;
    if (exec_go) begin
      if (evict_en) act_d[evict_idx] = 1'b0;
      if (rel_en)   act_d[hit_idx_q] = 1'b0;
      if (ins_en)   act_d[ins_idx]   = 1'b1;
    end
  end

  always_comb begin
    res_d                = '0;
    res_d.status         = status;
    res_d.evicted_valid  = evict_en;
    res_d.evicted_id     = evict_en ? evict_id : '0;
    res_d.active_count   = active_d;
    res_d.rejected_total = rej_cnt_q + 32'(rej_en);
    res_d.evicted_total  = ev_cnt_q + 32'(evict_en);
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  // ---------------------------------------------------------------- registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      scan_idx_q   <= '0;
      hit_found_q  <= 1'b0;
      free_found_q <= 1'b0;
      slow_found_q <= 1'b0;
      old_found_q  <= 1'b0;
      act_q        <= '0;
      active_q     <= '0;
      rej_cnt_q    <= '0;
      ev_cnt_q     <= '0;
      res_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cmd_pop_o) begin
        scan_idx_q   <= '0;
        hit_found_q  <= 1'b0;
        free_found_q <= 1'b0;
        slow_found_q <= 1'b0;
        old_found_q  <= 1'b0;
      end else if (scan_en) begin
        if (!scan_last) scan_idx_q <= scan_idx_q + IdxW'(1);
        if (hit_take)  hit_found_q  <= 1'b1;
        if (free_take) free_found_q <= 1'b1;
        if (slow_take) slow_found_q <= 1'b1;
        if (old_take)  old_found_q  <= 1'b1;
      end
      if (exec_go) begin
        act_q       <= act_d;
        active_q    <= active_d;
        rej_cnt_q   <= res_d.rejected_total;
        ev_cnt_q    <= res_d.evicted_total;
        res_valid_q <= 1'b1;
      end else if (res_valid_q && res_pop_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) cmd_q <= cmd_i;
    if (hit_take)  hit_idx_q  <= scan_idx_q;
    if (free_take) free_idx_q <= scan_idx_q;
    if (slow_take) begin
      slow_idx_q  <= scan_idx_q;
      slow_full_q <= e_full;
      slow_qlen_q <= e_qlen;
      slow_id_q   <= e_id;
    end
    if (old_take) begin
      old_idx_q  <= scan_idx_q;
      old_time_q <= e_time;
      old_id_q   <= e_id;
    end
    if (exec_go) begin
      res_q <= res_d;
      if (ins_en) begin
        ids_q[ins_idx]   <= cmd_q.client_id;
        times_q[ins_idx] <= cmd_q.now_ms;
        qlen_q[ins_idx]  <= '0;
        full_q[ins_idx]  <= 1'b0;
      end else if (upd_en) begin
        qlen_q[hit_idx_q] <= cmd_q.queue_len;
        full_q[hit_idx_q] <= cmd_q.queue_full;
      end
    end
  end

  // ---------------------------------------------------------------- checks
  a_count_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q == 8'($countones(act_q)))
    else $error("active count differs from number of live entries");

  a_evict_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    exec_go && evict_en |-> act_q[evict_idx])
    else $error("eviction of an inactive entry");

  a_insert_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    exec_go && ins_en |-> (!act_q[ins_idx] || (evict_en && (ins_idx == evict_idx))))
    else $error("new client placed over a live entry");

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    exec_go |=> res_valid_q)
    else $error("finished command left no result");

endmodule

### rtl/client_admission_evict_table.sv
// Top level of the client admission table: configuration registers and the two parts.
//
//  channel    | handshake             | word
//  -----------+-----------------------+------------------------------------------------
//  request    | push / full           | req_type, client_id, takeover, queue_full,
//             |                       | can_send, queue_len, free_heap, largest_block,
//             |                       | now_ms
//  result     | empty / pop           | status, evicted_valid, evicted_client_id,
//             |                       | active_count, rejected_total, evicted_total
//  config     | psel/penable/pwrite   | register at paddr[4:2], 32-bit pwdata/prdata
//
// The back part first loads a command, then scans the table, which it walks a single
// entry at a time, and last executes the command and registers the result.
// The front queue holds two classified words, so requests are taken while the back
// part works and while a result waits to be popped; the back part stalls in its
// execute step until the result register is free.
// Reset clears the live bits of all entries at once: no clearing pass is needed.
// The can_send flag is accepted with each word; no decision depends on it.
module client_admission_evict_table #(
  parameter int unsigned TableDepth = cae_pkg::DefTableDepth
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // request queue side
  input  logic                        push,
  output logic                        full,
  input  logic [1:0]                  req_type_i,
  input  logic [31:0]                 client_id_i,
  input  logic                        takeover_i,
  input  logic                        queue_full_i,
  input  logic                        can_send_i,
  input  logic [15:0]                 queue_len_i,
  input  logic [31:0]                 free_heap_i,
  input  logic [31:0]                 largest_block_i,
  input  logic [31:0]                 now_ms_i,
  // result queue side
  output logic                        empty,
  input  logic                        pop,
  output logic [3:0]                  status_o,
  output logic                        evicted_valid_o,
  output logic [31:0]                 evicted_client_id_o,
  output logic [7:0]                  active_count_o,
  output logic [31:0]                 rejected_total_o,
  output logic [31:0]                 evicted_total_o,
  // configuration port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [cae_pkg::PaddrW-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import cae_pkg::*;

  cae_cfg_t    cfg_q;
  cae_cmd_t    cmd;
  cae_res_t    res;
  logic        cmd_valid, cmd_pop, res_valid;
  logic        cfg_wr;
  logic [2:0]  reg_idx;

  // ---------------------------------------------------------------- config
  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  // Writes must arrive only while idle (unchecked); past the last register they drop.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        RegMaxClients: cfg_q.max_clients <= pwdata[7:0];
        RegPolicy:     cfg_q.policy      <= pwdata[1:0];
        RegRejHeap:    cfg_q.rej_heap    <= pwdata;
        RegRejBlock:   cfg_q.rej_block   <= pwdata;
        RegShedHeap:   cfg_q.shed_heap   <= pwdata;
        RegShedBlock:  cfg_q.shed_block  <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      RegMaxClients: prdata = {24'd0, cfg_q.max_clients};
      RegPolicy:     prdata = {30'd0, cfg_q.policy};
      RegRejHeap:    prdata = cfg_q.rej_heap;
      RegRejBlock:   prdata = cfg_q.rej_block;
      RegShedHeap:   prdata = cfg_q.shed_heap;
      RegShedBlock:  prdata = cfg_q.shed_block;
      default:       prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- front
  // Classify pressure on arrival and queue the command.
  cae_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .push_i          (push),
    .full_o          (full),
    .req_type_i      (req_type_i),
    .client_id_i     (client_id_i),
    .takeover_i      (takeover_i),
    .queue_full_i    (queue_full_i),
    .queue_len_i     (queue_len_i),
    .free_heap_i     (free_heap_i),
    .largest_block_i (largest_block_i),
    .now_ms_i        (now_ms_i),
    .cmd_valid_o     (cmd_valid),
    .cmd_o           (cmd),
    .cmd_pop_i       (cmd_pop)
  );

  // ---------------------------------------------------------------- back
  // Scan the table, act on it and hold the result until popped.
  cae_back #(
    .TableDepth (TableDepth)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_pop_i   (pop)
  );

  assign empty               = !res_valid;
  assign status_o            = res.status;
  assign evicted_valid_o     = res.evicted_valid;
  assign evicted_client_id_o = res.evicted_id;
  assign active_count_o      = res.active_count;
  assign rejected_total_o    = res.rejected_total;
  assign evicted_total_o     = res.evicted_total;

endmodule
